[rtl/core/sug_pkg.sv]
// Shared constants, codes and control types for the subtractive uniform generator.
package sug_pkg;

	localparam int FRACTION_BITS_DEF = 32;
	localparam int LAG_LEN           = 55;
	localparam int LAG_SHORT         = 24;
	localparam int LAG_LONG          = 31;
	localparam int SCATTER_STEP      = 21;
	localparam int SCATTER_MOD       = 54;
	localparam int IDX_W             = 6;

	localparam logic [1:0] OP_RESTART  = 2'd0;
	localparam logic [1:0] OP_FRACTION = 2'd1;
	localparam logic [1:0] OP_INTEGER  = 2'd2;
	localparam logic [1:0] OP_COIN     = 2'd3;

	typedef struct packed {
		logic load_in;
		logic restart_init;
		logic scatter_step;
		logic refill_start;
		logic refill_issue;
		logic pos_advance;
		logic capture;
		logic multiply;
		logic out_load;
	} sug_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       range_empty;
		logic       pos_wrap;
		logic       cnt_end;
		logic       out_free;
	} sug_status_t;

endpackage

[rtl/core/sug_ctrl.sv]
// Sequencing state machine for the subtractive uniform generator.
module sug_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  sug_pkg::sug_status_t status,
	output sug_pkg::sug_cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_SCAT   = 4'd2;
	localparam logic [3:0] ST_REFILL = 4'd3;
	localparam logic [3:0] ST_DRAIN  = 4'd4;
	localparam logic [3:0] ST_READ   = 4'd5;
	localparam logic [3:0] ST_CAPT   = 4'd6;
	localparam logic [3:0] ST_MUL    = 4'd7;
	localparam logic [3:0] ST_DONE   = 4'd8;

	logic [3:0] state_q, state_d;
	logic [1:0] pass_q, pass_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		pass_d  = pass_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (status.op == sug_pkg::OP_RESTART) begin
					cmd.restart_init = 1'b1;
					state_d          = ST_SCAT;
				end else if (status.op == sug_pkg::OP_INTEGER && status.range_empty) begin
					state_d = ST_DONE;
				end else begin
					cmd.pos_advance = 1'b1;
					if (status.pos_wrap) begin
						cmd.refill_start = 1'b1;
						pass_d           = 2'd1;
						state_d          = ST_REFILL;
					end else begin
						state_d = ST_READ;
					end
				end
			end
			ST_SCAT: begin
				cmd.scatter_step = 1'b1;
				if (status.cnt_end) begin
					cmd.refill_start = 1'b1;
					pass_d           = 2'd3;
					state_d          = ST_REFILL;
				end
			end
			ST_REFILL: begin
				cmd.refill_issue = 1'b1;
				if (status.cnt_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last difference of the pass is written in this cycle
				if (pass_q == 2'd1) begin
					state_d = (status.op == sug_pkg::OP_RESTART) ? ST_DONE : ST_READ;
				end else begin
					pass_d           = pass_q - 2'd1;
					cmd.refill_start = 1'b1;
					state_d          = ST_REFILL;
				end
			end
			ST_READ: begin
				state_d = ST_CAPT;
			end
			ST_CAPT: begin
				cmd.capture = 1'b1;
				state_d     = ST_MUL;
			end
			ST_MUL: begin
				cmd.multiply = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pass_q  <= 2'd0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

endmodule

[rtl/core/sug_dp.sv]
// Datapath of the subtractive uniform generator: lag table, counters and result logic.
module sug_dp #(
	parameter int FRACTION_BITS = sug_pkg::FRACTION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sug_pkg::sug_cmd_t    cmd,
	output sug_pkg::sug_status_t status,
	input  logic [31:0]          seed,
	input  logic [1:0]           op,
	input  logic signed [31:0]   range_low,
	input  logic signed [31:0]   range_high,
	input  logic [32:0]          prob,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [31:0]          fraction,
	output logic signed [31:0]   integer_value,
	output logic                 heads
);

	localparam int FB = FRACTION_BITS;
	localparam int IW = sug_pkg::IDX_W;
	localparam logic [63:0] START_WIDE = (FB >= 32) ?
		(64'd4 << ((FB >= 32) ? (FB - 32) : 0)) :
		(64'd4 >> ((FB < 32) ? (32 - FB) : 0));
	localparam logic [FB-1:0] START_VAL =
		(START_WIDE == 64'd0) ? FB'(1) : START_WIDE[FB-1:0];

	logic [FB-1:0]      lag_q [sug_pkg::LAG_LEN];
	logic [sug_pkg::LAG_LEN-1:0] valid_q;

	logic [IW-1:0]      pos_q;
	logic [IW-1:0]      cnt_q;
	logic [IW-1:0]      idx_q;
	logic [FB-1:0]      cur_q, prev_q;
	logic [1:0]         op_q;
	logic [31:0]        lo_q, hi_q;
	logic [32:0]        prob_q;
	logic [FB-1:0]      rd_a_q, rd_b_q;
	logic               va_q, vb_q;
	logic               wr_s1;
	logic [IW-1:0]      k_s1;
	logic [31:0]        frac_q;
	logic [64:0]        prod_q;
	logic               out_valid_q;
	logic [31:0]        fraction_q, integer_q;
	logic               heads_q;

	logic [FB-1:0]      seed_conv;
	logic [FB+31:0]     seed_wide;
	logic [FB+31:0]     frac_wide;
	logic [FB-1:0]      a_eff, b_eff;
	logic [IW-1:0]      addr_a, addr_b;
	logic               wr_en;
	logic [IW-1:0]      wr_addr;
	logic [FB-1:0]      wr_data;
	logic [IW:0]        idx_sum;
	logic [32:0]        span;
	logic signed [33:0] sum34, hi34;
	logic [31:0]        ival;

	assign seed_wide = {seed, {FB{1'b0}}} >> 32;
	assign seed_conv = seed_wide[FB-1:0];
	assign a_eff     = va_q ? rd_a_q : '0;
	assign b_eff     = vb_q ? rd_b_q : '0;
	assign frac_wide = {a_eff, 32'd0} >> FB;

	assign addr_a = cmd.refill_issue ? cnt_q : pos_q;
	assign addr_b = (cnt_q < IW'(sug_pkg::LAG_SHORT)) ? cnt_q + IW'(sug_pkg::LAG_LONG)
	                                                  : cnt_q - IW'(sug_pkg::LAG_SHORT);

	assign idx_sum = {1'b0, idx_q} + (IW+1)'(sug_pkg::SCATTER_STEP);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = cur_q;
		if (cmd.restart_init) begin
			wr_en   = 1'b1;
			wr_addr = IW'(sug_pkg::LAG_LEN - 1);
			wr_data = seed_conv;
		end else if (cmd.scatter_step) begin
			wr_en = 1'b1;
		end else if (wr_s1) begin
			wr_en   = 1'b1;
			wr_addr = k_s1;
			wr_data = a_eff - b_eff;
		end
	end

	// table storage and registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			lag_q[wr_addr] <= wr_data;
		end
		rd_a_q <= lag_q[addr_a];
		rd_b_q <= lag_q[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			va_q    <= 1'b0;
			vb_q    <= 1'b0;
		end else begin
			if (cmd.restart_init) begin
				// drop every entry except the seed slot
				valid_q <= {1'b1, {(sug_pkg::LAG_LEN-1){1'b0}}};
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			va_q <= valid_q[addr_a];
			vb_q <= valid_q[addr_b];
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			wr_s1 <= 1'b0;
			k_s1  <= '0;
		end else begin
			wr_s1 <= cmd.refill_issue;
			k_s1  <= cnt_q;
			if (cmd.restart_init) begin
				pos_q <= '0;
				cnt_q <= IW'(1);
				idx_q <= IW'(sug_pkg::SCATTER_STEP);
			end else begin
				if (cmd.pos_advance) begin
					pos_q <= (pos_q >= IW'(sug_pkg::LAG_LEN - 1)) ? IW'(1) : pos_q + IW'(1);
				end
				if (cmd.refill_start) begin
					cnt_q <= '0;
				end else if (cmd.scatter_step || cmd.refill_issue) begin
					cnt_q <= cnt_q + IW'(1);
				end
				if (cmd.scatter_step) begin
					idx_q <= (idx_sum >= (IW+1)'(sug_pkg::SCATTER_MOD)) ?
						IW'(idx_sum - (IW+1)'(sug_pkg::SCATTER_MOD)) : idx_sum[IW-1:0];
				end
			end
		end
	end

	// operands and arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= op;
			lo_q   <= range_low;
			hi_q   <= range_high;
			prob_q <= prob;
		end
		if (cmd.restart_init) begin
			cur_q  <= START_VAL;
			prev_q <= seed_conv;
		end else if (cmd.scatter_step) begin
			cur_q  <= prev_q - cur_q;
			prev_q <= cur_q;
		end
		if (cmd.capture) begin
			frac_q <= frac_wide[31:0];
		end
		if (cmd.multiply) begin
			prod_q <= {33'd0, frac_q} * {32'd0, span};
		end
	end

	assign span  = {hi_q[31], hi_q} - {lo_q[31], lo_q} + 33'd1;
	assign sum34 = $signed({{2{lo_q[31]}}, lo_q}) + $signed({1'b0, prod_q[64:32]});
	assign hi34  = $signed({{2{hi_q[31]}}, hi_q});
	assign ival  = (sum34 > hi34) ? hi_q : sum34[31:0];

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (op_q)
				sug_pkg::OP_FRACTION: begin
					fraction_q <= frac_q;
					integer_q  <= 32'd0;
					heads_q    <= 1'b0;
				end
				sug_pkg::OP_INTEGER: begin
					if ($signed(lo_q) >= $signed(hi_q)) begin
						fraction_q <= 32'd0;
						integer_q  <= lo_q;
					end else begin
						fraction_q <= frac_q;
						integer_q  <= ival;
					end
					heads_q <= 1'b0;
				end
				sug_pkg::OP_COIN: begin
					fraction_q <= frac_q;
					integer_q  <= 32'd0;
					heads_q    <= ({1'b0, frac_q} <= prob_q);
				end
				default: begin
					fraction_q <= 32'd0;
					integer_q  <= 32'd0;
					heads_q    <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign fraction      = fraction_q;
	assign integer_value = integer_q;
	assign heads         = heads_q;

	assign status.op          = op_q;
	assign status.range_empty = ($signed(lo_q) >= $signed(hi_q));
	assign status.pos_wrap    = (pos_q >= IW'(sug_pkg::LAG_LEN - 1));
	assign status.cnt_end     = (cnt_q == IW'(sug_pkg::LAG_LEN - 1));
	assign status.out_free    = !out_valid_q || out_ready;

endmodule

[rtl/core/subtractive_uniform_generator_unit.sv]
// Top level of the lag-55 subtractive uniform generator.
// One item at a time: a draw is accepted, then goes through decode, table read, capture,
// multiply and done before its result is loaded. A draw that runs past entry 54 first
// refills the 55-entry table, one table entry per cycle through the single write port.
// A restart takes 54 scatter steps and three refill passes. Reset (arst_n, async) clears
// the table to zeros through per-entry valid bits, the read position and the seed.
module subtractive_uniform_generator_unit #(
	parameter int FRACTION_BITS = sug_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [31:0]        seed,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         op,
	input  logic signed [31:0] range_low,
	input  logic signed [31:0] range_high,
	input  logic [32:0]        prob,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        fraction,
	output logic signed [31:0] integer_value,
	output logic               heads
);

	sug_pkg::sug_cmd_t    cmd;
	sug_pkg::sug_status_t status;
	logic [31:0]          seed_q;

	assign cfg_ready = 1'b1;

	// hold the seed register for the next restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= 32'd0;
		end else if (cfg_valid && cfg_ready) begin
			seed_q <= seed;
		end
	end

	sug_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	sug_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.seed          (seed_q),
		.op            (op),
		.range_low     (range_low),
		.range_high    (range_high),
		.prob          (prob),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.fraction      (fraction),
		.integer_value (integer_value),
		.heads         (heads)
	);

endmodule
